/* hdl/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// Battery charge sequencer package
// Shared types, codes and constants for the charge sequencer.
// ----------------------------------------------------------------------------
package bcs_pkg;

  // Field and register widths.
  localparam int unsigned TimerW   = 10;
  localparam int unsigned AdcW     = 15;
  localparam int unsigned CurW     = 15;
  localparam int unsigned StopW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned ProdW    = 23;

  // Converter word decoding and scaling to Q7.8 amps.
  localparam logic [AdcW-1:0] AdcValidMask = 15'h6000;
  localparam logic [AdcW-1:0] AdcDataMask  = 15'h0FFE;
  localparam logic [10:0]     AmpsScaleQ8  = 11'd1669;

  // Delay register reset values in seconds.
  localparam logic [TimerW-1:0] DevCheckRst = 10'd5;
  localparam logic [TimerW-1:0] StabRst     = 10'd10;
  localparam logic [TimerW-1:0] FinishRst   = 10'd900;

  typedef enum logic {
    CmdTick,
    CmdCharge
  } cmd_e;

  typedef enum logic [1:0] {
    ModeOff,
    ModeTwo,
    ModeThree,
    ModeEight
  } mode_e;

  typedef enum logic [1:0] {
    ErrOk,
    ErrNoBattery,
    ErrNoAc,
    ErrDevFault
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCurrentStop,
    CfgDeviceCheck,
    CfgStabilise,
    CfgFinishDelay
  } cfg_idx_e;

  // Configuration registers.
  typedef struct packed {
    logic [StopW-1:0]  current_stop_amps;
    logic [TimerW-1:0] device_check_secs;
    logic [TimerW-1:0] stabilise_secs;
    logic [TimerW-1:0] finish_delay_secs;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    cmd_e            command;
    mode_e           requested_mode;
    logic            ac_present;
    logic            device_healthy;
    logic            bank_full;
    logic            battery_connected;
    logic [AdcW-1:0] adc_word;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic            power_enabled;
    logic            relay_mode_two;
    logic            relay_mode_eight;
    mode_e           active_mode;
    err_e            error_code;
    logic            busy_res;
    logic [CurW-1:0] current_q8;
    logic            charge_finished;
  } out_item_t;

  // Sequencer state.
  typedef struct packed {
    logic              power_on;
    mode_e             stored_mode;
    logic              measure_enabled;
    logic [CurW-1:0]   current_value;
    logic [TimerW-1:0] check_cnt;
    logic [TimerW-1:0] stab_cnt;
    logic [TimerW-1:0] finish_cnt;
    err_e              last_error;
    logic              start_pending;
  } state_t;

  // A delay register holding zero loads as one second.
  function automatic logic [TimerW-1:0] delay_load(input logic [TimerW-1:0] secs);
    return (secs == '0) ? TimerW'(1) : secs;
  endfunction

endpackage

/* hdl/bcs_if.sv */
// ----------------------------------------------------------------------------
// Battery charge sequencer channels
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface bcs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  requested_mode;
  logic        ac_present;
  logic        device_healthy;
  logic        bank_full;
  logic        battery_connected;
  logic [14:0] adc_word;

  modport source (
    output valid, command, requested_mode, ac_present, device_healthy,
           bank_full, battery_connected, adc_word,
    input  ready
  );
  modport sink (
    input  valid, command, requested_mode, ac_present, device_healthy,
           bank_full, battery_connected, adc_word,
    output ready
  );
endinterface

interface bcs_out_if;
  logic        valid;
  logic        ready;
  logic        power_enabled;
  logic        relay_mode_two;
  logic        relay_mode_eight;
  logic [1:0]  active_mode;
  logic [1:0]  error_code;
  logic        busy_res;
  logic [14:0] current_q8;
  logic        charge_finished;

  modport source (
    output valid, power_enabled, relay_mode_two, relay_mode_eight, active_mode,
           error_code, busy_res, current_q8, charge_finished,
    input  ready
  );
  modport sink (
    input  valid, power_enabled, relay_mode_two, relay_mode_eight, active_mode,
           error_code, busy_res, current_q8, charge_finished,
    output ready
  );
endinterface

/* hdl/bcs_step.sv */
// ----------------------------------------------------------------------------
// Battery charge sequencer step
// Next state and result for one beat: start checks, measurement, end of
// charge and the three delay countdowns.
// ----------------------------------------------------------------------------
module bcs_step
  import bcs_pkg::*;
(
  input  cfg_t      cfg_i,
  input  state_t    state_i,
  input  in_item_t  item_i,
  output state_t    state_o,
  output out_item_t result_o
);

  logic [ProdW-1:0] prod;
  logic [CurW-1:0]  conv_cur;
  logic             adc_valid;
  logic             chk_run;
  logic             stab_run;
  logic             fin_run;
  logic             finished;
  state_t           st;

  // Converter word to Q7.8 amps.
  assign prod      = ProdW'(item_i.adc_word & AdcDataMask) * ProdW'(AmpsScaleQ8);
  assign conv_cur  = prod[ProdW-1:8];
  assign adc_valid = (item_i.adc_word & AdcValidMask) == AdcValidMask;

  assign chk_run  = state_i.check_cnt != '0;
  assign stab_run = state_i.stab_cnt != '0;
  assign fin_run  = state_i.finish_cnt != '0;

  // Sequencer update.
  always_comb begin
    st       = state_i;
    finished = 1'b0;
    unique case (item_i.command)
      CmdCharge: begin
        st.last_error    = ErrOk;
        st.start_pending = 1'b0;
        if (item_i.requested_mode == ModeOff) begin
          st.power_on    = 1'b0;
          st.stored_mode = ModeOff;
        end else if (!item_i.battery_connected) begin
          st.power_on   = 1'b0;
          st.last_error = ErrNoBattery;
        end else if (!item_i.ac_present) begin
          st.power_on   = 1'b0;
          st.last_error = ErrNoAc;
        end else begin
          st.start_pending = 1'b1;
          st.stored_mode   = item_i.requested_mode;
          st.power_on      = 1'b1;
          st.check_cnt     = delay_load(cfg_i.device_check_secs);
        end
      end
      CmdTick: begin
        // Measurement.
        if (!state_i.power_on || !item_i.ac_present) begin
          st.current_value   = '0;
          st.measure_enabled = 1'b0;
        end else if (state_i.measure_enabled && adc_valid) begin
          st.current_value = conv_cur;
        end

        // End of charge check.
        if (state_i.power_on && item_i.ac_present) begin
          if (cfg_i.current_stop_amps != '0) begin
            if (item_i.bank_full &&
                ({1'b0, st.current_value[CurW-1:8]} < cfg_i.current_stop_amps) &&
                !fin_run) begin
              st.finish_cnt = delay_load(cfg_i.finish_delay_secs);
            end
          end else if (item_i.bank_full) begin
            st.power_on      = 1'b0;
            st.stored_mode   = ModeOff;
            st.last_error    = ErrOk;
            st.start_pending = 1'b0;
            finished         = 1'b1;
          end
        end

        // Device check countdown.
        if (chk_run) begin
          st.check_cnt = st.check_cnt - TimerW'(1);
          if (st.check_cnt == '0) begin
            if (st.power_on) begin
              if (!item_i.device_healthy) begin
                st.power_on    = 1'b0;
                st.stored_mode = ModeOff;
                st.last_error  = ErrDevFault;
              end else begin
                st.stab_cnt = delay_load(cfg_i.stabilise_secs);
              end
            end
            st.start_pending = 1'b0;
          end
        end

        // Stabilise countdown; it runs only if it was running when the beat began.
        if (stab_run) begin
          st.stab_cnt = st.stab_cnt - TimerW'(1);
          if (st.stab_cnt == '0) begin
            st.measure_enabled = 1'b1;
          end
        end

        // Finish countdown.
        if (fin_run) begin
          st.finish_cnt = st.finish_cnt - TimerW'(1);
          if (st.finish_cnt == '0) begin
            st.power_on      = 1'b0;
            st.stored_mode   = ModeOff;
            st.last_error    = ErrOk;
            st.start_pending = 1'b0;
            finished         = 1'b1;
          end
        end
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  assign state_o = st;

  // Result reflects the state after this beat.
  always_comb begin
    result_o.power_enabled    = st.power_on;
    result_o.relay_mode_two   = st.stored_mode == ModeTwo;
    result_o.relay_mode_eight = st.stored_mode == ModeEight;
    result_o.active_mode      = st.power_on ? st.stored_mode : ModeOff;
    result_o.error_code       = st.last_error;
    result_o.busy_res         = st.start_pending;
    result_o.current_q8       = st.power_on ? st.current_value : '0;
    result_o.charge_finished  = finished;
  end

endmodule

/* hdl/battery_charge_sequencer.sv */
// ----------------------------------------------------------------------------
// Battery charge sequencer
// Sequences a mains charger through start, device check, stabilisation,
// current measurement and end of charge, one result beat per input beat.
// ----------------------------------------------------------------------------
//   Channel   Dir  Handshake        Payload
//   in_i      in   valid/ready      command, mode, status flags, adc_word
//   out_o     out  valid/ready      relays, mode, error, busy, current, done
//   cfg_*     in   write enable     index 0..3, 10-bit data
//
// A beat is captured in an input register, then the step logic updates the
// sequencer state and fills the result register. One beat per cycle is
// sustained while the receiver holds ready high. A new beat is taken into
// an empty input register while a finished result waits. Reset clears the
// state and loads the delay registers with 5, 10 and 900 seconds.
// ----------------------------------------------------------------------------
module battery_charge_sequencer
  import bcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bcs_in_if.sink              in_i,
  bcs_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  state_t    state_q, state_d;
  in_item_t  in_item_q, in_item_d;
  logic      in_vld_q;
  out_item_t out_item_q, out_item_d;
  logic      out_vld_q;
  logic      in_take;
  logic      advance;

  // Handshake control.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_item_d.command           = cmd_e'(in_i.command);
    in_item_d.requested_mode    = mode_e'(in_i.requested_mode);
    in_item_d.ac_present        = in_i.ac_present;
    in_item_d.device_healthy    = in_i.device_healthy;
    in_item_d.bank_full         = in_i.bank_full;
    in_item_d.battery_connected = in_i.battery_connected;
    in_item_d.adc_word          = in_i.adc_word;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_stop_amps <= '0;
      cfg_q.device_check_secs <= DevCheckRst;
      cfg_q.stabilise_secs    <= StabRst;
      cfg_q.finish_delay_secs <= FinishRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCurrentStop: cfg_q.current_stop_amps <= cfg_data_i[StopW-1:0];
        CfgDeviceCheck: cfg_q.device_check_secs <= cfg_data_i;
        CfgStabilise:   cfg_q.stabilise_secs    <= cfg_data_i;
        CfgFinishDelay: cfg_q.finish_delay_secs <= cfg_data_i;
        default:        cfg_q                   <= cfg_q;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_take || (in_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
  end

  bcs_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (out_item_d)
  );

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= advance || (out_vld_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.power_enabled    = out_item_q.power_enabled;
  assign out_o.relay_mode_two   = out_item_q.relay_mode_two;
  assign out_o.relay_mode_eight = out_item_q.relay_mode_eight;
  assign out_o.active_mode      = out_item_q.active_mode;
  assign out_o.error_code       = out_item_q.error_code;
  assign out_o.busy_res         = out_item_q.busy_res;
  assign out_o.current_q8       = out_item_q.current_q8;
  assign out_o.charge_finished  = out_item_q.charge_finished;

endmodule

/* bench/tb_battery_charge_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge sequencer testbench
// Drives command and tick beats through the valid/ready input channel and
// checks every status beat against a cycle-free model of the sequencer kept
// in this bench. A short directed plan walks start, refusal, device check,
// measurement and both ways to end a charge. Random beats follow under
// several register settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_battery_charge_sequencer;
  import bcs_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int HoldCycles = 300;

  // One step of the directed plan: a register write or an input beat,
  // optionally with a status that is written out by hand.
  typedef struct {
    bit          is_reg;
    cfg_idx_e    reg_idx;
    logic [9:0]  reg_val;
    in_item_t    beat;
    bit          typed;
    out_item_t   want;
  } plan_row_t;

  // One random phase: register values, length and back-pressure pattern.
  typedef struct {
    logic [9:0] stop;
    logic [9:0] chk;
    logic [9:0] stab;
    logic [9:0] fin;
    int         beats;
    int         idle_mode;
    bit         hold;
    bit         pause;
  } regime_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bcs_in_if  in_ch();
  bcs_out_if out_ch();

  battery_charge_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Model copy of the registers and the sequencer state.
  cfg_t              regs;
  logic              pwr;
  mode_e             mode_q;
  logic              meas_en;
  logic [CurW-1:0]   amps_q8;
  logic [TimerW-1:0] chk_left;
  logic [TimerW-1:0] stab_left;
  logic [TimerW-1:0] fin_left;
  err_e              err_q;
  logic              busy_q;

  out_item_t status_due[$];
  plan_row_t plan[$];
  regime_t   regimes[6];

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_request;
  int stall_left;
  int cycle_count;
  int mismatches;
  int beats_sent;
  int status_seen;
  int reg_writes;
  int endings_seen;
  int faults_seen;

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d status beats outstanding",
             cycle_count, status_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // A delay register holding zero counts as one second.
  function automatic logic [TimerW-1:0] secs_or_one(input logic [TimerW-1:0] secs);
    return (secs == '0) ? TimerW'(1) : secs;
  endfunction

  function automatic void charger_reset();
    regs.current_stop_amps = '0;
    regs.device_check_secs = DevCheckRst;
    regs.stabilise_secs    = StabRst;
    regs.finish_delay_secs = FinishRst;
    pwr       = 1'b0;
    mode_q    = ModeOff;
    meas_en   = 1'b0;
    amps_q8   = '0;
    chk_left  = '0;
    stab_left = '0;
    fin_left  = '0;
    err_q     = ErrOk;
    busy_q    = 1'b0;
  endfunction

  function automatic void charger_off();
    pwr    = 1'b0;
    mode_q = ModeOff;
    err_q  = ErrOk;
    busy_q = 1'b0;
  endfunction

  // Advance the model by one input beat and return the status it produces.
  function automatic out_item_t charger_step(input in_item_t b);
    out_item_t         r;
    logic              done;
    logic              chk_run;
    logic              stab_run;
    logic              fin_run;
    logic [ProdW-1:0]  prod;
    done = 1'b0;
    if (b.command == CmdCharge) begin
      err_q  = ErrOk;
      busy_q = 1'b0;
      if (b.requested_mode == ModeOff) begin
        charger_off();
      end else if (!b.battery_connected) begin
        pwr   = 1'b0;
        err_q = ErrNoBattery;
      end else if (!b.ac_present) begin
        pwr   = 1'b0;
        err_q = ErrNoAc;
      end else begin
        busy_q   = 1'b1;
        mode_q   = b.requested_mode;
        pwr      = 1'b1;
        chk_left = secs_or_one(regs.device_check_secs);
      end
    end else begin
      chk_run  = (chk_left != '0);
      stab_run = (stab_left != '0);
      fin_run  = (fin_left != '0);

      // Measurement comes first on a tick.
      if (!pwr || !b.ac_present) begin
        amps_q8 = '0;
        meas_en = 1'b0;
      end else if (meas_en && ((b.adc_word & AdcValidMask) == AdcValidMask)) begin
        prod    = ProdW'(b.adc_word & AdcDataMask) * ProdW'(AmpsScaleQ8);
        amps_q8 = prod[ProdW-1:8];
      end

      // End of charge: threshold arms the finish delay, otherwise bank full ends now.
      if (pwr && b.ac_present) begin
        if (regs.current_stop_amps != '0) begin
          if (b.bank_full && ({1'b0, amps_q8[CurW-1:8]} < regs.current_stop_amps) &&
              fin_left == '0) begin
            fin_left = secs_or_one(regs.finish_delay_secs);
          end
        end else if (b.bank_full) begin
          charger_off();
          done = 1'b1;
        end
      end

      // Countdowns that were running when the tick began.
      if (chk_run) begin
        chk_left = chk_left - TimerW'(1);
        if (chk_left == '0) begin
          if (pwr) begin
            if (!b.device_healthy) begin
              charger_off();
              err_q = ErrDevFault;
            end else begin
              stab_left = secs_or_one(regs.stabilise_secs);
            end
          end
          busy_q = 1'b0;
        end
      end
      if (stab_run) begin
        stab_left = stab_left - TimerW'(1);
        if (stab_left == '0) meas_en = 1'b1;
      end
      if (fin_run) begin
        fin_left = fin_left - TimerW'(1);
        if (fin_left == '0) begin
          charger_off();
          done = 1'b1;
        end
      end
    end

    r.power_enabled    = pwr;
    r.relay_mode_two   = (mode_q == ModeTwo);
    r.relay_mode_eight = (mode_q == ModeEight);
    r.active_mode      = pwr ? mode_q : ModeOff;
    r.error_code       = err_q;
    r.busy_res         = busy_q;
    r.current_q8       = pwr ? amps_q8 : '0;
    r.charge_finished  = done;
    return r;
  endfunction

  function automatic in_item_t beat_of(input cmd_e c, input mode_e m, input bit ac,
                                       input bit ok, input bit full, input bit batt,
                                       input logic [AdcW-1:0] adc);
    in_item_t b;
    b.command           = c;
    b.requested_mode    = m;
    b.ac_present        = ac;
    b.device_healthy    = ok;
    b.bank_full         = full;
    b.battery_connected = batt;
    b.adc_word          = adc;
    return b;
  endfunction

  function automatic plan_row_t beat_row(input in_item_t b);
    plan_row_t p;
    p.is_reg  = 1'b0;
    p.reg_idx = CfgCurrentStop;
    p.reg_val = '0;
    p.beat    = b;
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  // Status with the charger off, relays dropped and the given error.
  function automatic plan_row_t known_row(input in_item_t b, input err_e e);
    plan_row_t p;
    p = beat_row(b);
    p.typed = 1'b1;
    p.want.error_code = e;
    return p;
  endfunction

  function automatic plan_row_t reg_row(input cfg_idx_e idx, input logic [9:0] val);
    plan_row_t p;
    p.is_reg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    p.beat    = '0;
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  // Mostly well-formed traffic: occasional starts, ticks with AC and a
  // valid converter word most of the time, and a share of pure noise.
  function automatic in_item_t random_beat();
    logic [$bits(in_item_t)-1:0] raw;
    in_item_t b;
    int pick;
    raw  = $bits(in_item_t)'($urandom);
    b    = in_item_t'(raw);
    pick = $urandom_range(99);
    if (pick < 8) return b;
    if (pick < 16) begin
      b.command           = CmdCharge;
      b.requested_mode    = mode_e'($urandom_range(3));
      b.battery_connected = ($urandom_range(99) < 85);
      b.ac_present        = ($urandom_range(99) < 85);
    end else begin
      b.command        = CmdTick;
      b.ac_present     = ($urandom_range(99) < 93);
      b.device_healthy = ($urandom_range(99) < 90);
      b.bank_full      = ($urandom_range(99) < 12);
      if ($urandom_range(99) < 85) b.adc_word[14:13] = 2'b11;
    end
    return b;
  endfunction

  // Drop valid, wait for every outstanding status beat, then let the block settle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgCurrentStop: regs.current_stop_amps = val[StopW-1:0];
      CfgDeviceCheck: regs.device_check_secs = val;
      CfgStabilise:   regs.stabilise_secs    = val;
      default:        regs.finish_delay_secs = val;
    endcase
    reg_writes++;
  endtask

  // Offer one beat, with random gaps ahead of it, and record its status once taken.
  task automatic send_beat(input in_item_t b, input bit typed, input out_item_t want);
    out_item_t next;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.command           <= b.command;
    in_ch.requested_mode    <= b.requested_mode;
    in_ch.ac_present        <= b.ac_present;
    in_ch.device_healthy    <= b.device_healthy;
    in_ch.bank_full         <= b.bank_full;
    in_ch.battery_connected <= b.battery_connected;
    in_ch.adc_word          <= b.adc_word;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    next = charger_step(b);
    status_due.push_back(typed ? want : next);
    beats_sent++;
  endtask

  task automatic check_field(input string what, input logic [14:0] want,
                             input logic [14:0] seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
      mismatches++;
    end
  endtask

  task automatic check_status();
    out_item_t want;
    if (status_due.size() == 0) begin
      $display("%0t ns: status beat with none expected, expected none, actual power %0b",
               $time, out_ch.power_enabled);
      mismatches++;
      return;
    end
    want = status_due.pop_front();
    check_field("power_enabled", 15'(want.power_enabled), 15'(out_ch.power_enabled));
    check_field("relay_mode_two", 15'(want.relay_mode_two), 15'(out_ch.relay_mode_two));
    check_field("relay_mode_eight", 15'(want.relay_mode_eight),
                15'(out_ch.relay_mode_eight));
    check_field("active_mode", 15'(want.active_mode), 15'(out_ch.active_mode));
    check_field("error_code", 15'(want.error_code), 15'(out_ch.error_code));
    check_field("busy_res", 15'(want.busy_res), 15'(out_ch.busy_res));
    check_field("current_q8", want.current_q8, out_ch.current_q8);
    check_field("charge_finished", 15'(want.charge_finished),
                15'(out_ch.charge_finished));
    status_seen++;
    if (want.charge_finished) endings_seen++;
    if (want.error_code == ErrDevFault) faults_seen++;
  endtask

  // Status receiver: check each accepted beat, then pick ready for the next edge.
  initial begin
    out_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_status();
      if (stall_request) begin
        stall_left    = HoldCycles;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus.
  initial begin
    rst_ni                  <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.command           <= CmdTick;
    in_ch.requested_mode    <= ModeOff;
    in_ch.ac_present        <= 1'b0;
    in_ch.device_healthy    <= 1'b0;
    in_ch.bank_full         <= 1'b0;
    in_ch.battery_connected <= 1'b0;
    in_ch.adc_word          <= '0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= CfgCurrentStop;
    cfg_data_i              <= '0;
    stall_request = 1'b0;
    mismatches    = 0;
    beats_sent    = 0;
    status_seen   = 0;
    reg_writes    = 0;
    endings_seen  = 0;
    faults_seen   = 0;
    send_idle_pct = 28;
    recv_idle_pct = 63;
    charger_reset();

    // Reset defaults: refusals, a start and a switch-off.
    plan.push_back(known_row(beat_of(CmdTick, ModeOff, 0, 0, 0, 0, '0), ErrOk));
    // Battery is checked before AC.
    plan.push_back(known_row(beat_of(CmdCharge, ModeEight, 0, 1, 0, 0, '0), ErrNoBattery));
    plan.push_back(known_row(beat_of(CmdCharge, ModeTwo, 0, 1, 0, 1, '0), ErrNoAc));
    plan.push_back(beat_row(beat_of(CmdCharge, ModeEight, 1, 1, 0, 1, '0)));
    plan.push_back(known_row(beat_of(CmdCharge, ModeOff, 1, 1, 0, 1, '0), ErrOk));
    // Short delays, ending on bank full alone.
    plan.push_back(reg_row(CfgDeviceCheck, 10'd1));
    plan.push_back(reg_row(CfgStabilise, 10'd1));
    plan.push_back(reg_row(CfgFinishDelay, 10'd2));
    plan.push_back(beat_row(beat_of(CmdCharge, ModeThree, 1, 1, 0, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h7FFF)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h7FFF)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h7FFF)));
    // An invalid word keeps the last current; a valid zero word clears it.
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h1FFF)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h6000)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 0, 1, 0, 1, 15'h7FFF)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 1, 1, 15'h7FFF)));
    // Device fault at the end of the check delay.
    plan.push_back(beat_row(beat_of(CmdCharge, ModeTwo, 1, 1, 0, 1, '0)));
    plan.push_back(known_row(beat_of(CmdTick, ModeOff, 1, 0, 0, 1, '0), ErrDevFault));
    // Highest threshold: full-scale current is still below it.
    plan.push_back(reg_row(CfgCurrentStop, 10'd255));
    plan.push_back(beat_row(beat_of(CmdCharge, ModeEight, 1, 1, 0, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 1, 1, 15'h7FFF)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h7FFF)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 0, 1, 15'h7FFF)));
    // Zero finish delay counts as one, and the finish fires with power already off.
    plan.push_back(reg_row(CfgFinishDelay, 10'd0));
    plan.push_back(beat_row(beat_of(CmdCharge, ModeThree, 1, 1, 0, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 1, 1, 1, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdCharge, ModeOff, 1, 1, 0, 1, '0)));
    plan.push_back(beat_row(beat_of(CmdTick, ModeOff, 0, 0, 0, 0, '0)));

    regimes[0] = '{10'd0,   10'd1,    10'd1,    10'd1,    230, 0, 1'b1, 1'b0};
    regimes[1] = '{10'h3FF, 10'd2,    10'd3,    10'd4,    230, 0, 1'b0, 1'b0};
    regimes[2] = '{10'd40,  10'd1023, 10'd1023, 10'd1023,  60, 1, 1'b0, 1'b0};
    regimes[3] = '{10'd60,  10'd0,    10'd0,    10'd0,    240, 1, 1'b0, 1'b1};
    regimes[4] = '{10'd1,   10'd4,    10'd2,    10'd1023, 230, 2, 1'b0, 1'b0};
    regimes[5] = '{10'd100, 10'd1,    10'd2,    10'd6,    250, 2, 1'b0, 1'b0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed plan.
    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end

    // Random phases, each under its own register setting.
    foreach (regimes[p]) begin
      write_reg(CfgCurrentStop, regimes[p].stop);
      write_reg(CfgDeviceCheck, regimes[p].chk);
      write_reg(CfgStabilise, regimes[p].stab);
      write_reg(CfgFinishDelay, regimes[p].fin);
      case (regimes[p].idle_mode)
        0:       begin send_idle_pct = 28; recv_idle_pct = 63; end
        1:       begin send_idle_pct = 63; recv_idle_pct = 28; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int k = 0; k < regimes[p].beats; k++) begin
        // Long receiver hold-off while beats keep coming.
        if (regimes[p].hold && k == 40) stall_request = 1'b1;
        // Sender waits until every status beat is back.
        if (regimes[p].pause && k == 100) settle();
        send_beat(random_beat(), 1'b0, '0);
      end
    end

    settle();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d input beats over %0d register writes; %0d status beats checked.",
             beats_sent, reg_writes, status_seen);
    $display("Charges ended: %0d, device faults: %0d, mismatches: %0d.",
             endings_seen, faults_seen, mismatches);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bcs_pkg.sv
hdl/bcs_if.sv
hdl/bcs_step.sv
hdl/battery_charge_sequencer.sv
bench/tb_battery_charge_sequencer.sv
